/* design/gbn_pkg.sv */
package gbn_pkg;

  // Fixed field widths.
  localparam int CRD_W    = 16;
  localparam int CNT_OUT_W = 7;
  localparam int THR_W    = 15;
  localparam int FB_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // Internal arithmetic widths: sides, areas, reference area, products.
  localparam int SIDE_W = 18;
  localparam int AREA_W = 36;
  localparam int REF_W  = 36;
  localparam int PROD_W = 54;
  localparam int ENTRY_W = 4 * CRD_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

  // Register reset values.
  localparam logic [THR_W-1:0] THR_RESET  = 15'd179;
  localparam logic [FB_W-1:0]  FB_RESET   = 4'd8;
  localparam logic             MODE_RESET = 1'b0;

  // Overlap mode codes.
  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_MIN   = 1'b1;

  typedef struct packed {
    logic signed [CRD_W-1:0] left_x;
    logic signed [CRD_W-1:0] top_y;
    logic signed [CRD_W-1:0] right_x;
    logic signed [CRD_W-1:0] bottom_y;
    logic signed [CRD_W-1:0] box_score;
    logic                    last_box;
  } box_in_t;

  typedef struct packed {
    logic                    keep;
    logic signed [CRD_W-1:0] out_left_x;
    logic signed [CRD_W-1:0] out_top_y;
    logic signed [CRD_W-1:0] out_right_x;
    logic signed [CRD_W-1:0] out_bottom_y;
    logic signed [CRD_W-1:0] score_echo;
    logic [CNT_OUT_W-1:0]    kept_count;
    logic                    table_full;
    logic                    frame_end;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_READ,
    ST_DIFF,
    ST_KAREA,
    ST_INTER,
    ST_REF,
    ST_RHS,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

/* design/greedy_box_nms_top.sv */
// Greedy box suppression, one box per command.
//
// Input word: a box (inclusive corners), its score and a last-box flag, taken
// at a rising edge with start high and busy low. Boxes of a frame must come in
// descending score order. Busy stays high until the result is produced.
// Result word: the box echoed with keep, kept_count, table_full and frame_end,
// shown on out_result for exactly one cycle while out_valid is high. The
// receiver cannot stall; a new start may be given in the strobe cycle.
// Each stored box is compared in the states READ, DIFF, KAREA, INTER, REF, RHS
// and CMP; the comparison stops at the first stored box that suppresses the
// new box, else all stored boxes are examined. One shared multiplier serves
// the box area once per box and three products per comparison (kept area,
// intersection, threshold times reference area).
// Configuration: plain write port, cfg_we with cfg_index and cfg_wdata; write
// only while idle. Reset (rst_n low at a clock edge) empties the kept table,
// restores the register defaults and drops any box in flight. The table also
// empties after the result of a box that carries last_box.
module greedy_box_nms_top
  import gbn_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word
  input  logic                 start,
  output logic                 busy,
  input  box_in_t              in_box,
  // result word
  output logic                 out_valid,
  output result_t              out_result,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  // Configuration registers.
  logic [THR_W-1:0] thr_r;
  logic [FB_W-1:0]  fb_r;
  logic             mode_r;

  // Sequencer.
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;   // boxes stored in the kept table
  logic [CNT_W-1:0] idx_r;     // stored box under comparison
  logic             keep_r;

  // Box under test and its sides.
  box_in_t                  box_r;
  logic signed [SIDE_W-1:0] w_r, h_r;
  logic signed [AREA_W-1:0] area_r;

  // Per-comparison datapath.
  logic [ENTRY_W-1:0]       rd_data_r;
  logic signed [SIDE_W-1:0] kw_r, kh_r, ow_r, oh_r;
  logic signed [AREA_W-1:0] karea_r, inter_r;
  logic signed [REF_W-1:0]  ref_r;
  logic signed [PROD_W-1:0] rhs_r;

  // Kept table.
  logic [ENTRY_W-1:0] kept_mem [MAX_KEPT];

  // Shared multiplier.
  logic signed [REF_W-1:0]  mul_a;
  logic signed [SIDE_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [CRD_W-1:0]  k_lx, k_ty, k_rx, k_by;
  logic signed [CRD_W-1:0]  min_rx, max_lx, min_by, max_ty;
  logic signed [SIDE_W-1:0] in_w, in_h;
  logic signed [AREA_W-1:0] ref_min;
  logic signed [PROD_W-1:0] lhs;
  logic                     suppress;
  logic                     last_cmp;
  logic                     table_at_max;
  logic                     store_box;
  logic                     accept;
  logic                     inter_pos;

  assign accept       = start && !busy;
  assign table_at_max = (count_r == CNT_W'(MAX_KEPT));
  assign store_box    = keep_r && !table_at_max;
  assign last_cmp     = (CNT_W'(idx_r + 1'b1) == count_r);

  // Width and height of the incoming box.
  assign in_w = SIDE_W'(in_box.right_x) - SIDE_W'(in_box.left_x) + SIDE_W'(1);
  assign in_h = SIDE_W'(in_box.bottom_y) - SIDE_W'(in_box.top_y) + SIDE_W'(1);

  // Stored box fields, packed as {left, top, right, bottom}.
  assign k_lx = rd_data_r[4*CRD_W-1:3*CRD_W];
  assign k_ty = rd_data_r[3*CRD_W-1:2*CRD_W];
  assign k_rx = rd_data_r[2*CRD_W-1:CRD_W];
  assign k_by = rd_data_r[CRD_W-1:0];

  assign min_rx = (box_r.right_x  < k_rx) ? box_r.right_x  : k_rx;
  assign max_lx = (box_r.left_x   > k_lx) ? box_r.left_x   : k_lx;
  assign min_by = (box_r.bottom_y < k_by) ? box_r.bottom_y : k_by;
  assign max_ty = (box_r.top_y    > k_ty) ? box_r.top_y    : k_ty;

  // Intersection counts only when both overlap sides are positive.
  assign inter_pos = (ow_r > SIDE_W'(0)) && (oh_r > SIDE_W'(0));

  assign ref_min = (area_r < karea_r) ? area_r : karea_r;

  // Scaled intersection; inter_r is never negative.
  assign lhs      = PROD_W'(inter_r) <<< fb_r;
  assign suppress = (lhs > rhs_r);

  assign mul_p = mul_a * mul_b;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      fb_r   <= FB_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_FRAC_BITS: fb_r   <= cfg_wdata[FB_W-1:0];
        CFG_MODE:      mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_AREA;
      ST_AREA:  state_nxt = (count_r == '0) ? ST_DONE : ST_READ;
      ST_READ:  state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_KAREA;
      ST_KAREA: state_nxt = ST_INTER;
      ST_INTER: state_nxt = ST_REF;
      ST_REF:   state_nxt = ST_RHS;
      ST_RHS:   state_nxt = ST_CMP;
      ST_CMP:   state_nxt = (suppress || last_cmp) ? ST_DONE : ST_READ;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: busy and the multiplier operand select.
  always_comb begin
    busy  = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_AREA: begin
        mul_a = REF_W'(w_r);
        mul_b = h_r;
      end
      ST_KAREA: begin
        mul_a = REF_W'(kw_r);
        mul_b = kh_r;
      end
      ST_INTER: begin
        mul_a = inter_pos ? REF_W'(ow_r) : '0;
        mul_b = inter_pos ? oh_r : '0;
      end
      ST_RHS: begin
        mul_a = ref_r;
        mul_b = $signed({{(SIDE_W-THR_W){1'b0}}, thr_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Control registers: table count, compare index, keep flag, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      keep_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (accept) begin
        idx_r  <= '0;
        keep_r <= 1'b1;
      end
      if (state_r == ST_CMP) begin
        if (suppress) keep_r <= 1'b0;
        idx_r <= CNT_W'(idx_r + 1'b1);
      end
      if (state_r == ST_DONE) begin
        out_valid <= 1'b1;
        // Clear the table after the last box of the frame.
        if (box_r.last_box)  count_r <= '0;
        else if (store_box)  count_r <= CNT_W'(count_r + 1'b1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      box_r <= in_box;
      w_r   <= in_w;
      h_r   <= in_h;
    end
    unique case (state_r)
      ST_AREA:  area_r <= AREA_W'(mul_p);
      ST_DIFF: begin
        kw_r <= SIDE_W'(k_rx) - SIDE_W'(k_lx) + SIDE_W'(1);
        kh_r <= SIDE_W'(k_by) - SIDE_W'(k_ty) + SIDE_W'(1);
        ow_r <= SIDE_W'(min_rx) - SIDE_W'(max_lx) + SIDE_W'(1);
        oh_r <= SIDE_W'(min_by) - SIDE_W'(max_ty) + SIDE_W'(1);
      end
      ST_KAREA: karea_r <= AREA_W'(mul_p);
      ST_INTER: inter_r <= AREA_W'(mul_p);
      ST_REF: begin
        if (mode_r == MODE_MIN) ref_r <= REF_W'(ref_min);
        else ref_r <= REF_W'(area_r) + REF_W'(karea_r) - REF_W'(inter_r);
      end
      ST_RHS:   rhs_r <= mul_p;
      default: ;
    endcase
  end

  // Kept table: read the entry under comparison, store a surviving box while the table has room.
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) rd_data_r <= kept_mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && store_box) begin
      kept_mem[count_r[ADDR_W-1:0]] <= {box_r.left_x, box_r.top_y,
                                        box_r.right_x, box_r.bottom_y};
    end
  end

  // Result word, registered in the DONE state; it holds until the next result.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_result.keep         <= keep_r;
      out_result.out_left_x   <= box_r.left_x;
      out_result.out_top_y    <= box_r.top_y;
      out_result.out_right_x  <= box_r.right_x;
      out_result.out_bottom_y <= box_r.bottom_y;
      out_result.score_echo   <= box_r.box_score;
      out_result.kept_count   <= store_box ? CNT_OUT_W'(count_r + 1'b1)
                                           : CNT_OUT_W'(count_r);
      out_result.table_full   <= keep_r && table_at_max;
      out_result.frame_end    <= box_r.last_box;
    end
  end

endmodule
